// ----- hdl/gamepad_report_button_remapper_unit_macros.svh -----
// Assertion macros for the gamepad report button remapper unit.
// Uses clk and rst of the including module; compiles to nothing under SYNTHESIS.
`ifndef GAMEPAD_REPORT_BUTTON_REMAPPER_UNIT_MACROS_SVH
`define GAMEPAD_REPORT_BUTTON_REMAPPER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Condition in the same cycle.
`define GPRBR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// Condition in the following cycle.
`define GPRBR_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define GPRBR_ASSERT_NOW(lbl, pre, post, msg)
`define GPRBR_ASSERT_NXT(lbl, pre, post, msg)
`endif

`endif

// ----- hdl/gprbr_pkg.sv -----
// Shared types, codes and reset constants for the gamepad report button remapper.
// No dependencies.
package gprbr_pkg;

  localparam int NUM_PORTS_DEF = 2;
  localparam int BTN_W         = 16;
  localparam int STICK_W       = 32;
  localparam int MAP_WORDS     = 4;
  localparam int MAP_WORD_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  typedef logic [BTN_W-1:0]                      btn_t;
  typedef logic [STICK_W-1:0]                    stick_t;
  typedef logic [MAP_WORDS-1:0][MAP_WORD_W-1:0]  map_table_t;
  typedef logic [CFG_IDX_W-1:0]                  cfg_idx_t;
  typedef logic [1:0]                            kind_t;

  typedef struct packed {
    btn_t   held;
    btn_t   mapped;
    btn_t   mapped_new;
    stick_t raw_stick;
    stick_t mapped_stick;
  } port_state_t;

  localparam cfg_idx_t CFG_MAP_WORD_0  = 3'd0;
  localparam cfg_idx_t CFG_MAP_WORD_1  = 3'd1;
  localparam cfg_idx_t CFG_MAP_WORD_2  = 3'd2;
  localparam cfg_idx_t CFG_MAP_WORD_3  = 3'd3;
  localparam cfg_idx_t CFG_SWAP_STICKS = 3'd4;
  localparam cfg_idx_t CFG_PORT_ENABLE = 3'd5;

  localparam kind_t KIND_NONE        = 2'd0;
  localparam kind_t KIND_UNSUPPORTED = 2'd1;
  localparam kind_t KIND_DIGITAL     = 2'd2;
  localparam kind_t KIND_ANALOG      = 2'd3;

  localparam logic [7:0] STATUS_OK  = 8'h00;
  localparam logic [7:0] ID_DIGITAL = 8'h41;
  localparam logic [7:0] ID_ANALOG  = 8'h73;

  localparam stick_t STICK_CENTER_FLIP = 32'h8080_8080;

  localparam map_table_t MAP_RESET = {
    64'h8000_4000_2000_1000,
    64'h0800_0400_0200_0100,
    64'h0080_0040_0020_0010,
    64'h0008_0004_0002_0001
  };
  localparam logic [1:0] SWAP_RESET   = 2'b00;
  localparam logic [1:0] ENABLE_RESET = 2'b11;

endpackage

// ----- hdl/gprbr_map.sv -----
// Button remap: ORs together the table masks of all held buttons.
// Depends on gprbr_pkg.
module gprbr_map (
  input  gprbr_pkg::btn_t       btn,
  input  gprbr_pkg::map_table_t map_table,
  output gprbr_pkg::btn_t       mapped
);

  localparam int WordIdxW = $clog2(gprbr_pkg::MAP_WORDS);
  localparam int BitIdxW  = $clog2(gprbr_pkg::MAP_WORD_W);

  always_comb begin
    mapped = '0;
    for (int i = 0; i < gprbr_pkg::BTN_W; i++) begin
      if (btn[i]) begin
        mapped = mapped | map_table[WordIdxW'(i >> 2)]
                                   [BitIdxW'((i & 3) * gprbr_pkg::BTN_W) +: gprbr_pkg::BTN_W];
      end
    end
  end

endmodule

// ----- hdl/gamepad_report_button_remapper_unit.sv -----
// Top level of the gamepad report button remapper: input register, per-port state,
// result register and configuration registers. Depends on gprbr_pkg, gprbr_map
// and gamepad_report_button_remapper_unit_macros.svh.
//
// Usage: one controller report is a request on the s_ channel (port on s_tuser,
// status, id, button bytes and stick bytes on s_tdata). Each request yields exactly
// one result on the m_ channel (pad kind on m_tuser, button words and sticks on
// m_tdata), in request order.
// Flow: an accepted request is registered in the input register, then processed against
// the port state into the result register, from which its result is presented on m_.
// Throughput: one request per cycle while m_tready is high, including back-to-back requests
// for the same port; the port state read-modify-write is combinational and written as it fires.
// Stall: while m_tready is low the result is held, one more request is taken into
// the input register, and then s_tready drops until the result is taken.
// Reset (rst, synchronous): all port state clears to zero, the map is the
// identity map, stick swap is off and both ports are enabled.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next edge
// and are meant to be issued while no request is in flight.
`include "gamepad_report_button_remapper_unit_macros.svh"

module gamepad_report_button_remapper_unit #(
  parameter int NUM_PORTS = gprbr_pkg::NUM_PORTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // status[7:0], id[15:8], button_bytes[31:16], stick_bytes[63:32]
  input  logic [63:0]                       s_tdata,
  // port_index[0]
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // raw_buttons[15:0], raw_new[31:16], mapped_buttons[47:32], mapped_new[63:48],
  // raw_sticks[95:64], mapped_sticks[127:96]
  output logic [127:0]                      m_tdata,
  // pad_kind[1:0]
  output logic [1:0]                        m_tuser,
  input  logic                              cfg_we,
  input  gprbr_pkg::cfg_idx_t               cfg_index,
  input  logic [gprbr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PortW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  // Configuration registers.
  gprbr_pkg::map_table_t map_table;
  logic [1:0]            swap_sticks;
  logic [1:0]            port_enable;

  // Input register.
  logic              in_valid;
  logic              in_port;
  logic [7:0]        in_status;
  logic [7:0]        in_id;
  logic [15:0]       in_buttons;
  gprbr_pkg::stick_t in_sticks;

  // Result register.
  logic              out_valid;
  gprbr_pkg::kind_t  res_kind;
  gprbr_pkg::btn_t   res_raw_buttons;
  gprbr_pkg::btn_t   res_raw_new;
  gprbr_pkg::btn_t   res_mapped;
  gprbr_pkg::btn_t   res_mapped_new;
  gprbr_pkg::stick_t res_raw_sticks;
  gprbr_pkg::stick_t res_mapped_sticks;

  // Per-port state.
  gprbr_pkg::port_state_t port_state [NUM_PORTS];

  logic                   advance;
  logic                   fire;
  logic                   sel;
  logic [PortW-1:0]       idx;
  logic                   id_ok;
  logic                   good;
  logic                   map_upd;
  gprbr_pkg::kind_t       kind_next;
  gprbr_pkg::btn_t        btn;
  gprbr_pkg::btn_t        map_result;
  gprbr_pkg::btn_t        raw_new_next;
  gprbr_pkg::stick_t      rs;
  gprbr_pkg::port_state_t state_old;
  gprbr_pkg::port_state_t state_next;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  assign sel       = (NUM_PORTS > 1) ? in_port : 1'b0;
  assign idx       = PortW'(sel);
  assign state_old = port_state[idx];

  assign id_ok = (in_id == gprbr_pkg::ID_DIGITAL) || (in_id == gprbr_pkg::ID_ANALOG);
  assign good  = (in_status == gprbr_pkg::STATUS_OK) && id_ok;
  assign btn   = ~in_buttons;
  assign rs    = in_sticks ^ gprbr_pkg::STICK_CENTER_FLIP;
  assign map_upd = good && port_enable[sel];

  gprbr_map u_map (
    .btn       (btn),
    .map_table (map_table),
    .mapped    (map_result)
  );

  always_comb begin
    if (in_status != gprbr_pkg::STATUS_OK) begin
      kind_next = gprbr_pkg::KIND_NONE;
    end else if (!id_ok) begin
      kind_next = gprbr_pkg::KIND_UNSUPPORTED;
    end else if (in_id == gprbr_pkg::ID_DIGITAL) begin
      kind_next = gprbr_pkg::KIND_DIGITAL;
    end else begin
      kind_next = gprbr_pkg::KIND_ANALOG;
    end
  end

  always_comb begin
    state_next   = state_old;
    raw_new_next = '0;
    if (!good) begin
      state_next.held       = '0;
      state_next.mapped     = '0;
      state_next.mapped_new = '0;
    end else begin
      raw_new_next         = btn & ~state_old.held;
      state_next.held      = btn;
      state_next.raw_stick = rs;
      if (map_upd) begin
        state_next.mapped     = map_result;
        state_next.mapped_new = map_result & ~state_old.mapped;
        if (swap_sticks[sel]) begin
          state_next.mapped_stick = {rs[15:0], rs[31:16]};
        end else begin
          state_next.mapped_stick = rs;
        end
      end
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      map_table   <= gprbr_pkg::MAP_RESET;
      swap_sticks <= gprbr_pkg::SWAP_RESET;
      port_enable <= gprbr_pkg::ENABLE_RESET;
      port_state  <= '{default: '0};
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        port_state[idx] <= state_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          gprbr_pkg::CFG_MAP_WORD_0:  map_table[0] <= cfg_data;
          gprbr_pkg::CFG_MAP_WORD_1:  map_table[1] <= cfg_data;
          gprbr_pkg::CFG_MAP_WORD_2:  map_table[2] <= cfg_data;
          gprbr_pkg::CFG_MAP_WORD_3:  map_table[3] <= cfg_data;
          gprbr_pkg::CFG_SWAP_STICKS: swap_sticks  <= cfg_data[1:0];
          gprbr_pkg::CFG_PORT_ENABLE: port_enable  <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_port    <= s_tuser[0];
      in_status  <= s_tdata[7:0];
      in_id      <= s_tdata[15:8];
      in_buttons <= s_tdata[31:16];
      in_sticks  <= s_tdata[63:32];
    end
    if (fire) begin
      res_kind          <= kind_next;
      res_raw_buttons   <= state_next.held;
      res_raw_new       <= raw_new_next;
      res_mapped        <= state_next.mapped;
      res_mapped_new    <= state_next.mapped_new;
      res_raw_sticks    <= state_next.raw_stick;
      res_mapped_sticks <= state_next.mapped_stick;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res_kind;
  assign m_tdata  = {res_mapped_sticks, res_raw_sticks, res_mapped_new, res_mapped,
                     res_raw_new, res_raw_buttons};

  `GPRBR_ASSERT_NXT(a_bad_report_clears, fire && !good,
                    (res_raw_buttons == '0) && (res_raw_new == '0) &&
                    (res_mapped == '0) && (res_mapped_new == '0),
                    "bad report did not clear button state")
  `GPRBR_ASSERT_NOW(a_raw_new_subset, m_tvalid,
                    (res_raw_new & ~res_raw_buttons) == '0,
                    "raw_new has bits outside raw_buttons")
  `GPRBR_ASSERT_NOW(a_mapped_new_subset, m_tvalid,
                    (res_mapped_new & ~res_mapped) == '0,
                    "mapped_new has bits outside mapped_buttons")
  `GPRBR_ASSERT_NOW(a_backpressure_only_full, !s_tready,
                    in_valid && out_valid && !m_tready,
                    "input stalled while a stage is free")

endmodule

// ----- sim/tb_gamepad_report_button_remapper_unit.sv -----
// Self-checking testbench for gamepad_report_button_remapper_unit: drives controller reports
// and register writes, and compares every result with a built-in model of the remapper.
// Depends on gprbr_pkg and the RTL of the unit; it needs no other files.
module tb_gamepad_report_button_remapper_unit;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 6;

  typedef struct {
    gprbr_pkg::kind_t  kind;
    gprbr_pkg::btn_t   raw_buttons;
    gprbr_pkg::btn_t   raw_new;
    gprbr_pkg::btn_t   mapped_buttons;
    gprbr_pkg::btn_t   mapped_new;
    gprbr_pkg::stick_t raw_sticks;
    gprbr_pkg::stick_t mapped_sticks;
  } pad_result_t;

  class pad_remap_scoreboard;
    gprbr_pkg::map_table_t  map_table;
    logic [1:0]             swap_bits;
    logic [1:0]             enable_bits;
    gprbr_pkg::port_state_t ports[gprbr_pkg::NUM_PORTS_DEF];
    pad_result_t            awaited_results[$];
    int                     failures;
    int                     checked;

    function new();
      map_table   = gprbr_pkg::MAP_RESET;
      swap_bits   = gprbr_pkg::SWAP_RESET;
      enable_bits = gprbr_pkg::ENABLE_RESET;
      foreach (ports[p]) ports[p] = '0;
      failures    = 0;
      checked     = 0;
    endfunction

    function void note_register(gprbr_pkg::cfg_idx_t idx,
                                logic [gprbr_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        gprbr_pkg::CFG_MAP_WORD_0, gprbr_pkg::CFG_MAP_WORD_1,
        gprbr_pkg::CFG_MAP_WORD_2, gprbr_pkg::CFG_MAP_WORD_3: begin
          map_table[2'(idx - gprbr_pkg::CFG_MAP_WORD_0)] = value;
        end
        gprbr_pkg::CFG_SWAP_STICKS: swap_bits = value[1:0];
        gprbr_pkg::CFG_PORT_ENABLE: enable_bits = value[1:0];
        default: ;
      endcase
    endfunction

    function pad_result_t remap_report(logic port, logic [7:0] status, logic [7:0] id,
                                       gprbr_pkg::btn_t bytes, gprbr_pkg::stick_t sticks);
      pad_result_t       r;
      gprbr_pkg::btn_t   pressed;
      gprbr_pkg::btn_t   mapped;
      gprbr_pkg::stick_t centered;
      r.raw_new = '0;
      if (status != gprbr_pkg::STATUS_OK ||
          (id != gprbr_pkg::ID_DIGITAL && id != gprbr_pkg::ID_ANALOG)) begin
        // A bad transfer or an unknown device drops all button state of the port.
        r.kind = (status != gprbr_pkg::STATUS_OK) ? gprbr_pkg::KIND_NONE
                                                  : gprbr_pkg::KIND_UNSUPPORTED;
        ports[port].held       = '0;
        ports[port].mapped     = '0;
        ports[port].mapped_new = '0;
      end else begin
        pressed  = ~bytes;
        centered = sticks ^ gprbr_pkg::STICK_CENTER_FLIP;
        r.kind   = (id == gprbr_pkg::ID_DIGITAL) ? gprbr_pkg::KIND_DIGITAL
                                                 : gprbr_pkg::KIND_ANALOG;
        r.raw_new = pressed & ~ports[port].held;
        ports[port].held      = pressed;
        ports[port].raw_stick = centered;
        if (enable_bits[port]) begin
          mapped = '0;
          for (int i = 0; i < gprbr_pkg::BTN_W; i++) begin
            if (pressed[i]) mapped |= map_table[2'(i / 4)][6'((i % 4) * 16) +: 16];
          end
          ports[port].mapped_new   = mapped & ~ports[port].mapped;
          ports[port].mapped       = mapped;
          ports[port].mapped_stick = swap_bits[port] ? {centered[15:0], centered[31:16]}
                                                     : centered;
        end
      end
      r.raw_buttons    = ports[port].held;
      r.mapped_buttons = ports[port].mapped;
      r.mapped_new     = ports[port].mapped_new;
      r.raw_sticks     = ports[port].raw_stick;
      r.mapped_sticks  = ports[port].mapped_stick;
      return r;
    endfunction

    function void note_report(logic port, logic [7:0] status, logic [7:0] id,
                              gprbr_pkg::btn_t bytes, gprbr_pkg::stick_t sticks);
      awaited_results.push_back(remap_report(port, status, id, bytes, sticks));
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [1:0] user, logic [127:0] data);
      pad_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: kind 0x%0h data 0x%0h", user, data);
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      compare("pad_kind", 32'(want.kind), 32'(user));
      compare("raw_buttons", 32'(want.raw_buttons), 32'(data[15:0]));
      compare("raw_new", 32'(want.raw_new), 32'(data[31:16]));
      compare("mapped_buttons", 32'(want.mapped_buttons), 32'(data[47:32]));
      compare("mapped_new", 32'(want.mapped_new), 32'(data[63:48]));
      compare("raw_sticks", want.raw_sticks, data[95:64]);
      compare("mapped_sticks", want.mapped_sticks, data[127:96]);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [63:0]                      s_tdata;
  logic [0:0]                       s_tuser;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [127:0]                     m_tdata;
  logic [1:0]                       m_tuser;
  logic                             cfg_we;
  gprbr_pkg::cfg_idx_t              cfg_index;
  logic [gprbr_pkg::CFG_DATA_W-1:0] cfg_data;

  pad_remap_scoreboard sb;
  int  cycles;
  int  hold_left;
  int  sent;
  bit  hold_request;
  bit  quiet;

  gamepad_report_button_remapper_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: checks accepted results and applies random and long back-pressure.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  task automatic send_report(logic port, logic [7:0] status, logic [7:0] id,
                             gprbr_pkg::btn_t bytes, gprbr_pkg::stick_t sticks);
    if (!quiet && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= port;
    s_tdata  <= {sticks, bytes, id, status};
    do @(posedge clk); while (!s_tready);
    sb.note_report(port, status, id, bytes, sticks);
    sent++;
  endtask

  task automatic send_random_report();
    logic [7:0]      status;
    logic [7:0]      id;
    gprbr_pkg::btn_t bytes;
    int              pick;
    pick   = int'($urandom_range(99));
    status = gprbr_pkg::STATUS_OK;
    id     = $urandom_range(1) ? gprbr_pkg::ID_ANALOG : gprbr_pkg::ID_DIGITAL;
    if (pick < 8) begin
      status = 8'($urandom_range(255, 1));
      id     = 8'($urandom_range(255));
    end else if (pick < 16) begin
      id = 8'($urandom_range(255));
    end
    case ($urandom_range(3))
      0: bytes = 16'hffff;
      1: bytes = ~(gprbr_pkg::btn_t'(1) << $urandom_range(15));
      default: bytes = 16'($urandom);
    endcase
    send_report(1'($urandom_range(1)), status, id, bytes, $urandom);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(gprbr_pkg::cfg_idx_t idx,
                                logic [gprbr_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.note_register(idx, value);
  endtask

  task automatic load_setting(int phase);
    logic [gprbr_pkg::MAP_WORD_W-1:0] word;
    for (int w = 0; w < gprbr_pkg::MAP_WORDS; w++) begin
      case (phase)
        1: word = '1;
        2: word = '0;
        4: begin
          for (int k = 0; k < 4; k++) begin
            word[k * 16 +: 16] = gprbr_pkg::btn_t'(1) << $urandom_range(15);
          end
        end
        5: word = gprbr_pkg::MAP_RESET[2'(w)];
        default: word = {$urandom, $urandom};
      endcase
      write_register(gprbr_pkg::cfg_idx_t'(gprbr_pkg::CFG_MAP_WORD_0 + w), word);
    end
    write_register(gprbr_pkg::CFG_SWAP_STICKS,
                   64'((phase == 0 || phase == 4) ? 2'b11 : 2'(phase % 3)));
    write_register(gprbr_pkg::CFG_PORT_ENABLE,
                   64'((phase == 3) ? 2'b00 : (phase == 0 || phase >= 4)
                       ? 2'b11 : 2'(phase)));
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb           = new();
    clk          = 1'b0;
    cycles       = 0;
    hold_left    = 0;
    sent         = 0;
    hold_request = 0;
    quiet        = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    m_tready  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= gprbr_pkg::CFG_MAP_WORD_0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed reports against the reset configuration.
    send_report(0, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_DIGITAL, 16'hffff, 32'h8080_8080);
    send_report(0, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_DIGITAL, 16'h0000, 32'h0000_0000);
    send_report(0, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_ANALOG, 16'h0000, 32'hffff_ffff);
    send_report(0, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_ANALOG, 16'hfffe, 32'h7f7f_8181);
    send_report(1, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_ANALOG, 16'h5a5a, 32'h1234_5678);
    send_report(1, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_ANALOG, 16'ha5a5, 32'h9abc_def0);
    send_report(0, 8'h01, gprbr_pkg::ID_ANALOG, 16'h0000, 32'h0102_0304);
    send_report(0, 8'hff, gprbr_pkg::ID_DIGITAL, 16'h0000, 32'hffff_ffff);
    send_report(0, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_DIGITAL, 16'h0000, 32'h0000_0000);
    send_report(1, gprbr_pkg::STATUS_OK, 8'h00, 16'h0000, 32'h5555_aaaa);
    send_report(1, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_ANALOG, 16'h7fff, 32'haaaa_5555);
    send_report(1, gprbr_pkg::STATUS_OK, 8'hff, 16'h0000, 32'h0000_0000);
    send_report(1, gprbr_pkg::STATUS_OK, 8'h40, 16'h0000, 32'h0000_0000);
    send_report(1, gprbr_pkg::STATUS_OK, 8'h42, 16'h0000, 32'h0000_0000);
    send_report(1, gprbr_pkg::STATUS_OK, 8'h72, 16'h0000, 32'h0000_0000);
    send_report(1, gprbr_pkg::STATUS_OK, 8'h74, 16'h0000, 32'h0000_0000);
    send_report(1, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_DIGITAL, 16'hfff0, 32'h8000_0080);
    send_report(0, 8'h80, 8'h00, 16'hffff, 32'hffff_ffff);
    send_report(0, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_ANALOG, 16'h00ff, 32'hff00_ff00);
    send_report(0, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_ANALOG, 16'hff00, 32'h00ff_00ff);
    send_report(1, gprbr_pkg::STATUS_OK, gprbr_pkg::ID_DIGITAL, 16'hffff, 32'h8080_8080);
    wait_drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      load_setting(phase);
      quiet = (phase == 4);
      if (phase == 1) hold_request = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_report();
      wait_drain();
    end
    quiet = 0;
    repeat (10) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.failures++;
    end
    $display("Sent %0d reports over %0d register settings; %0d results checked, %0d failures.",
             sent, NUM_PHASES + 1, sb.checked, sb.failures);
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
